/* rtl/fbs_pkg.sv */
// Shared constants of the frame brightness score block.
package fbs_pkg;

    localparam int unsigned FBS_MAX_PIXELS = 4194304;
    // Largest count for which the pixel sum still fits in 30 bits.
    localparam int unsigned FBS_SUM_SAFE_CAP = 4210752;

    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned SUM_W = 30;
    localparam int unsigned COUNT_W = 23;
    localparam int unsigned MEAN_W = 24;
    localparam int unsigned SCORE_W = 7;

    localparam logic [PIXEL_W-1:0] PIXEL_FLOOR = 8'd40;

    // Mean breakpoints in Q8.16.
    localparam logic [MEAN_W-1:0] MEAN_LO = 24'(60 * 65536);
    localparam logic [MEAN_W-1:0] MEAN_HI = 24'(230 * 65536);
    localparam logic [MEAN_W-1:0] MEAN_MID = 24'(120 * 65536);

    // Distance from the middle fits in 23 bits; the slope 0.23 in Q0.16.
    localparam int unsigned DIST_W = 23;
    localparam int unsigned SLOPE_W = 14;
    localparam logic [SLOPE_W-1:0] SLOPE_Q16 = 14'd15073;
    localparam int unsigned PROD_W = DIST_W + SLOPE_W;

    localparam logic [SCORE_W-1:0] SCORE_TOP = 7'd100;
    localparam logic [SCORE_W-1:0] SCORE_KNEE = 7'd60;

endpackage

/* rtl/fbs_divider.sv */
// Restoring divider that forms the Q8.16 mean one quotient bit per cycle.
module fbs_divider
    import fbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_W-1:0]    sum,
    input  logic [COUNT_W-1:0]  count,
    output logic                done,
    output logic [MEAN_W-1:0]   quotient
);

    localparam int unsigned STEP_W = $clog2(MEAN_W);
    localparam int unsigned LOW_W = MEAN_W;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W-1:0]  div_reg, div_next;
    logic [LOW_W-1:0]    low_reg, low_next;
    logic [MEAN_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W:0]    trial;
    logic                fits;

    // The quotient is below 2^24, so the upper dividend bits start below the divisor.
    assign trial = {rem_reg, low_reg[LOW_W-1]};
    assign fits = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        low_next = low_reg;
        quo_next = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next = COUNT_W'(sum[SUM_W-1:8]);
            div_next = count;
            low_next = {sum[7:0], 16'd0};
        end
        else if (busy_reg)
        begin
            rem_next = fits ? COUNT_W'(trial - {1'b0, div_reg}) : trial[COUNT_W-1:0];
            low_next = {low_reg[LOW_W-2:0], 1'b0};
            quo_next = {quo_reg[MEAN_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(MEAN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/fbs_score.sv */
// Three-stage mapping from the Q8.16 mean to the brightness score.
module fbs_score
    import fbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MEAN_W-1:0]   mean,
    output logic                done,
    output logic [SCORE_W-1:0]  score
);

    logic                v1_reg, v2_reg, v3_reg;
    logic                direct1_reg, direct2_reg;
    logic [SCORE_W-1:0]  fixed1_reg, fixed2_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SCORE_W-1:0]  score_reg;

    logic                direct1_next;
    logic [SCORE_W-1:0]  fixed1_next;
    logic [DIST_W-1:0]   dist_next;
    logic [MEAN_W-1:0]   over;
    logic [5:0]          up;

    // Stage one: sort the mean into its range and do the cheap cases.
    always_comb
    begin
        over = mean - MEAN_HI;
        direct1_next = 1'b1;
        fixed1_next = '0;
        dist_next = '0;
        if (mean < MEAN_LO)
        begin
            fixed1_next = SCORE_W'(mean[MEAN_W-1:16]);
        end
        else if (mean > MEAN_HI)
        begin
            // The excess is at most 25.0, so the drop stays at or below 50.
            fixed1_next = SCORE_KNEE - SCORE_W'(over[MEAN_W-1:15]);
        end
        else
        begin
            direct1_next = 1'b0;
            dist_next = (mean >= MEAN_MID) ? DIST_W'(mean - MEAN_MID)
                                           : DIST_W'(MEAN_MID - mean);
        end
    end

    // Stage three: the product is Q.32; the penalty rounds up.
    assign up = 6'(prod_reg[PROD_W-1:32]) + 6'(|prod_reg[31:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        direct1_reg <= direct1_next;
        fixed1_reg <= fixed1_next;
        dist_reg <= dist_next;
        direct2_reg <= direct1_reg;
        fixed2_reg <= fixed1_reg;
        prod_reg <= PROD_W'(dist_reg) * PROD_W'(SLOPE_Q16);
        score_reg <= direct2_reg ? fixed2_reg : SCORE_TOP - SCORE_W'(up);
    end

    assign done = v3_reg;
    assign score = score_reg;

endmodule

/* rtl/frame_brightness_score.sv */
// Top level of the frame brightness score block: accumulators, sequencer, result register.
// Pixels without the last flag are taken at one pixel per cycle while accumulating.
// A last pixel starts the frame close: the divider forms the mean, the sequencer hands it on,
// the score unit maps it and the score goes into the result register, after which pixels
// are taken again; a held result stretches the close.
// Reset clears the accumulators, the sequencer and the result valid flag at once.
module frame_brightness_score
    import fbs_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = FBS_MAX_PIXELS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [PIXEL_W-1:0]  pixel,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SCORE_W-1:0]  brightness
);

    // Counting stops here so that the sum can never leave its 30 bits.
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_PIXELS < FBS_SUM_SAFE_CAP) ? MAX_PIXELS : FBS_SUM_SAFE_CAP);

    // The sequencer: accumulate, divide, hand the mean to the score unit, wait for it.
    typedef enum logic [3:0]
    {
        S_ACC   = 4'b0001,
        S_DIV   = 4'b0010,
        S_MEAN  = 4'b0100,
        S_SCORE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0]  brightness_reg, brightness_next;

    logic                in_beat;
    logic                close_start;
    logic                div_done;
    logic [MEAN_W-1:0]   quotient;
    logic [MEAN_W-1:0]   mean;
    logic                score_start;
    logic                score_done;
    logic [SCORE_W-1:0]  score;

    // Pixels are only taken while accumulating; the frame close owns the datapath.
    assign in_stall = (state_reg != S_ACC);
    assign in_beat = in_valid && !in_stall;
    assign close_start = in_beat && last;

    // An empty frame has mean zero whatever the divider returns.
    assign mean = (count_reg == '0) ? '0 : quotient;

    // The score may only start when the result register will be free for it.
    assign score_start = (state_reg == S_MEAN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        sum_next = sum_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        brightness_next = brightness_reg;

        // The pixel that closes a frame is counted before the division.
        if (in_beat && (pixel > PIXEL_FLOOR) && (count_reg < COUNT_CAP))
        begin
            sum_next = sum_reg + SUM_W'(pixel);
            count_next = count_reg + 1'b1;
        end

        case (state_reg)
            S_ACC:
            begin
                if (close_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                if (score_start)
                begin
                    state_next = S_SCORE;
                end
            end
            S_SCORE:
            begin
                if (score_done)
                begin
                    out_valid_next = 1'b1;
                    brightness_next = score;
                    sum_next = '0;
                    count_next = '0;
                    state_next = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            sum_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg <= sum_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        brightness_reg <= brightness_next;
    end

    // The divider takes the totals that include the closing pixel.
    fbs_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (close_start),
        .sum      (sum_next),
        .count    (count_next),
        .done     (div_done),
        .quotient (quotient)
    );

    fbs_score u_score
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (score_start),
        .mean  (mean),
        .done  (score_done),
        .score (score)
    );

    assign out_valid = out_valid_reg;
    assign brightness = brightness_reg;

    // A closing beat always stalls the input on the next cycle.
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        close_start |=> in_stall)
        else $error("input not stalled after frame close");

    // The score unit never finishes into a result register that is still held.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        score_start |=> !(out_valid_reg && out_stall && $past(out_valid_reg)))
        else $error("score started while result register blocked");

    // The count saturates at its cap.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_CAP)
        else $error("pixel count above cap");

    // Scores stay within 0..100.
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (brightness_reg <= SCORE_TOP))
        else $error("score out of range");

endmodule
